// File: rtl/nlt_pkg.sv
package nlt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Lost reports per health check
    localparam int MAX_LOST = 32;
    localparam int LOST_W   = $clog2(MAX_LOST + 1);

    // Field widths
    localparam int TIME_W   = 48;
    localparam int SHORT_W  = 16;
    localparam int LONG_W   = 64;
    localparam int MISS_W   = 4;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 4;
    localparam int TMO_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [MISS_W-1:0] MISS_SAT     = 4'hF;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 32'd30000000;
    localparam logic [MISS_W-1:0] MAX_MISS_RST = 4'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISS = 1'b1;

    typedef enum logic [1:0] {
        OP_ANNOUNCE = 2'd0,
        OP_PONG     = 2'd1,
        OP_HEALTH   = 2'd2,
        OP_PING     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_NEW          = 4'd0,
        STS_REJOIN       = 4'd1,
        STS_FULL         = 4'd2,
        STS_PONG_KNOWN   = 4'd3,
        STS_PONG_UNKNOWN = 4'd4,
        STS_LOST         = 4'd5,
        STS_CHECK_DONE   = 4'd6,
        STS_TARGET       = 4'd7,
        STS_NONE         = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [SHORT_W-1:0] nwk_addr;
        logic [LONG_W-1:0]  long_addr;
        logic [TIME_W-1:0]  now_us;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [SHORT_W-1:0] node_short;
        logic [LONG_W-1:0]  node_long;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } out_word_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [SHORT_W-1:0] nwk_addr;
        logic [LONG_W-1:0]  long_addr;
        logic [TIME_W-1:0]  heard;
        logic [MISS_W-1:0]  misses;
        logic               alive;
    } entry_t;

    // Per-entry verdict from the evaluation unit
    typedef struct packed {
        logic              match;
        logic              live;
        logic              miss;
        logic              dead;
        logic [MISS_W-1:0] misses_new;
    } eval_t;

    // Table index reported in the low bits of the slot field
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// File: rtl/node_liveness_table_top.sv
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_stall    in_word   (in_word_t)
// out       output     out_valid / out_stall  out_word  (out_word_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One word in flight at a time. A scan reads one table entry per cycle
// from the single read port of the entry memory. From one accepted input
// word to the next, the table is scanned and the result word is then held
// until the output is free. Announce, pong and ping select stop the scan
// at the first hit; a health check scans every entry. Reset clears the
// valid bits and round-robin pointer and loads the config defaults; no
// clearing pass. A stalled output pauses a health scan in place.
module node_liveness_table_top
    import nlt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [TMO_W-1:0]  timeout_reg;
    logic [MISS_W-1:0] max_miss_reg;

    in_word_t          item;
    logic              cur_valid;
    entry_t            rdata;
    eval_t             ev;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RST;
            max_miss_reg <= MAX_MISS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TMO_W-1:0];
                CFG_MAX_MISS: max_miss_reg <= cfg_data[MISS_W-1:0];
                default:      timeout_reg  <= timeout_reg;
            endcase
        end
    end

    nlt_entry_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    nlt_eval u_eval (
        .entry       (rdata),
        .entry_valid (cur_valid),
        .nwk_addr    (item.nwk_addr),
        .now_us      (item.now_us),
        .timeout_us  (timeout_reg),
        .max_miss    (max_miss_reg),
        .result      (ev)
    );

    nlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .item      (item),
        .cur_valid (cur_valid),
        .rdata     (rdata),
        .ev        (ev),
        .rd_addr   (rd_addr),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

endmodule

// File: rtl/nlt_entry_mem.sv
module nlt_entry_mem
    import nlt_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nlt_eval.sv
module nlt_eval
    import nlt_pkg::*;
(
    input  entry_t             entry,
    input  logic               entry_valid,
    input  logic [SHORT_W-1:0] nwk_addr,
    input  logic [TIME_W-1:0]  now_us,
    input  logic [TMO_W-1:0]   timeout_us,
    input  logic [MISS_W-1:0]  max_miss,
    output eval_t              result
);

    logic [TIME_W-1:0] gap;

    // Silence since last heard, wraps at 2^48
    assign gap = now_us - entry.heard;

    always_comb
    begin
        result.match = entry_valid && (entry.nwk_addr == nwk_addr);
        result.live  = entry_valid && entry.alive;
        result.miss  = result.live && (gap > {{(TIME_W-TMO_W){1'b0}}, timeout_us});
        // saturating miss count
        result.misses_new = (entry.misses == MISS_SAT) ? MISS_SAT
                                                       : entry.misses + 1'b1;
        result.dead  = (result.misses_new >= max_miss);
    end

endmodule

// File: rtl/nlt_ctrl.sv
module nlt_ctrl
    import nlt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word,
    output in_word_t         item,
    output logic             cur_valid,
    input  entry_t           rdata,
    input  eval_t            ev,
    output logic [IDX_W-1:0] rd_addr,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output entry_t           mem_wdata
);

    state_t                 state_reg, state_next;
    in_word_t               item_reg;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [LOST_W-1:0]      lost_reg, lost_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    out_word_t              res_reg, res_next;
    logic                   out_valid_reg;
    out_word_t              out_word_reg, out_next;
    logic                   out_load;

    logic                   accept;
    logic                   out_free;
    logic                   is_last;
    logic [IDX_W-1:0]       idx_inc;
    logic                   report;
    logic                   adv;
    logic                   stop_found;
    logic                   go_finish;
    logic                   free_any;
    logic [IDX_W-1:0]       free_slot;
    entry_t                 refresh_entry;

    // Common scan conditions
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cur_valid  = valid_reg[scan_idx_reg];
    assign is_last    = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign idx_inc    = (scan_idx_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                  : scan_idx_reg + 1'b1;
    assign report     = (item_reg.operation == OP_HEALTH) && ev.miss && ev.dead
                        && (lost_reg < LOST_W'(MAX_LOST));
    assign adv        = !(report && !out_free);
    assign stop_found = (((item_reg.operation == OP_ANNOUNCE)
                          || (item_reg.operation == OP_PONG)) && ev.match)
                        || ((item_reg.operation == OP_PING) && ev.live);
    assign go_finish  = stop_found || (adv && is_last);
    assign free_any   = free_found_reg || !cur_valid;
    assign free_slot  = free_found_reg ? free_idx_reg : scan_idx_reg;

    assign item      = item_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign rd_addr   = scan_idx_next;

    // Entry image after a node is heard
    always_comb
    begin
        refresh_entry.nwk_addr  = item_reg.nwk_addr;
        refresh_entry.long_addr = rdata.long_addr;
        refresh_entry.heard     = item_reg.now_us;
        refresh_entry.misses    = '0;
        refresh_entry.alive     = 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (go_finish)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = scan_idx_reg;
        mem_wdata       = refresh_entry;
        valid_next      = valid_reg;
        scan_idx_next   = scan_idx_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        lost_next       = lost_reg;
        ptr_next        = ptr_reg;
        res_next        = res_reg;
        out_load        = 1'b0;
        out_next        = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    scan_idx_next   = (in_word.operation == OP_PING) ? ptr_reg : '0;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    lost_next       = '0;
                end
            end
            S_SCAN:
            begin
                if (adv)
                begin
                    scan_idx_next = idx_inc;
                    cnt_next      = cnt_reg + 1'b1;
                end
                // lowest free entry seen so far
                if (!free_found_reg && !cur_valid)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end

                unique case (item_reg.operation)
                    OP_ANNOUNCE:
                    begin
                        if (ev.match)
                        begin
                            mem_we   = 1'b1;
                            res_next = '{status: STS_REJOIN,
                                         node_short: item_reg.nwk_addr,
                                         node_long: item_reg.long_addr,
                                         slot: to_slot(scan_idx_reg),
                                         last: 1'b1};
                        end
                        else if (is_last)
                        begin
                            if (free_any)
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = free_slot;
                                mem_wdata.long_addr  = item_reg.long_addr;
                                valid_next[free_slot] = 1'b1;
                                res_next = '{status: STS_NEW,
                                             node_short: item_reg.nwk_addr,
                                             node_long: item_reg.long_addr,
                                             slot: to_slot(free_slot),
                                             last: 1'b1};
                            end
                            else
                            begin
                                res_next = '{status: STS_FULL,
                                             node_short: item_reg.nwk_addr,
                                             node_long: item_reg.long_addr,
                                             slot: '0,
                                             last: 1'b1};
                            end
                        end
                    end
                    OP_PONG:
                    begin
                        if (ev.match)
                        begin
                            mem_we   = 1'b1;
                            res_next = '{status: STS_PONG_KNOWN,
                                         node_short: item_reg.nwk_addr,
                                         node_long: rdata.long_addr,
                                         slot: to_slot(scan_idx_reg),
                                         last: 1'b1};
                        end
                        else if (is_last)
                        begin
                            res_next = '{status: STS_PONG_UNKNOWN,
                                         node_short: item_reg.nwk_addr,
                                         node_long: '0,
                                         slot: '0,
                                         last: 1'b1};
                        end
                    end
                    OP_HEALTH:
                    begin
                        // miss bookkeeping, held while a lost word waits
                        if (ev.miss && adv)
                        begin
                            mem_we           = 1'b1;
                            mem_wdata        = rdata;
                            mem_wdata.misses = ev.misses_new;
                            mem_wdata.alive  = !ev.dead;
                        end
                        if (report && out_free)
                        begin
                            out_load  = 1'b1;
                            out_next  = '{status: STS_LOST,
                                          node_short: rdata.nwk_addr,
                                          node_long: rdata.long_addr,
                                          slot: to_slot(scan_idx_reg),
                                          last: 1'b0};
                            lost_next = lost_reg + 1'b1;
                        end
                        if (adv && is_last)
                        begin
                            res_next = '{status: STS_CHECK_DONE, node_short: '0,
                                         node_long: '0, slot: '0, last: 1'b1};
                        end
                    end
                    OP_PING:
                    begin
                        if (ev.live)
                        begin
                            ptr_next = idx_inc;
                            res_next = '{status: STS_TARGET,
                                         node_short: rdata.nwk_addr,
                                         node_long: rdata.long_addr,
                                         slot: to_slot(scan_idx_reg),
                                         last: 1'b1};
                        end
                        else if (is_last)
                        begin
                            res_next = '{status: STS_NONE, node_short: '0,
                                         node_long: '0, slot: '0, last: 1'b1};
                        end
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next = res_reg;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            lost_reg       <= '0;
            ptr_reg        <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cnt_reg        <= cnt_next;
            free_found_reg <= free_found_next;
            lost_reg       <= lost_next;
            ptr_reg        <= ptr_next;
            valid_reg      <= valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
        end
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_word_reg <= out_next;
        end
    end

endmodule
